@@ sv/char_grid_line_plotter_defines.svh @@
// ----------------------------------------------------------------------------
// char_grid_line_plotter_defines.svh
// Assertion macros for the character grid line plotter.
// ----------------------------------------------------------------------------
`ifndef CHAR_GRID_LINE_PLOTTER_DEFINES_SVH
`define CHAR_GRID_LINE_PLOTTER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define CGLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define CGLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cglp_pkg.sv @@
// ----------------------------------------------------------------------------
// cglp_pkg
// Types and constants for the character grid line plotter.
// ----------------------------------------------------------------------------
package cglp_pkg;

  typedef enum logic [2:0] {
    CMD_BEGIN  = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_SET_FG = 3'd2,
    CMD_SET_BG = 3'd3,
    CMD_HLINE  = 3'd4,
    CMD_VLINE  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOB      = 2'd1,
    ST_NONPRINT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_LN_CHK,
    S_LN_RD,
    S_LN_WR,
    S_RD_WAIT
  } state_t;

  localparam logic       CFG_ROWS   = 1'b0;
  localparam logic       CFG_COLS   = 1'b1;
  localparam logic [5:0] GRID_RESET = 6'd30;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_TILDE   = 8'd126;

endpackage

@@ sv/cglp_grid_mem.sv @@
// ----------------------------------------------------------------------------
// cglp_grid_mem
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cglp_grid_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] cells [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    rdata <= cells[raddr];
  end

endmodule

@@ sv/char_grid_line_plotter.sv @@
// Begin, set, unused and rejected read: result strobe in the cycle after start; rejected line: from the check state.
// Read cell: via the read-wait state. Line: check state, then read and write states per cell (read-modify-write).
// Clear: the sweep writes all 2^(RW+CW) entries (1024 at 32x32), one memory entry per cycle.
// One command at a time: start is taken again in the cycle done is high.
// After reset the same sweep fills the grid with spaces; busy is high meanwhile.
// Results are strobed by done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// char_grid_line_plotter
// Text-mode drawing engine: pen, draw character and lines over a cell grid.
// ----------------------------------------------------------------------------
`include "char_grid_line_plotter_defines.svh"

module char_grid_line_plotter #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic signed [7:0] distance,
  input  logic [5:0]        read_row,
  input  logic [5:0]        read_col,
  output logic              done,
  output logic [1:0]        status,
  output logic [7:0]        cell_char,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);
  import cglp_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam logic [6:0] ROW_MAX = 7'(MAX_ROWS);
  localparam logic [6:0] COL_MAX = 7'(MAX_COLS);

  state_t state, state_next;

  logic [5:0]        rows_cfg, cols_cfg;
  logic [5:0]        pen_row, pen_col;
  logic [7:0]        draw_char;
  logic              bg_mode;
  logic              vert;
  logic signed [7:0] offset;
  logic [5:0]        cur, hi, end_pos;
  logic [AW-1:0]     sweep_cnt;
  logic              sweep_reply;

  logic [5:0]        rows_eff, cols_eff, line_lim, pos, end6;
  logic signed [8:0] add_a, add_b, sum;
  logic              pen_ok, end_ok, read_ok, printable;
  logic [5:0]        ln_row, ln_col, ln_rm1, ln_cm1, rd_rm1, rd_cm1;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  function automatic logic [5:0] eff_limit(input logic [5:0] r, input logic [6:0] maxv);
    logic [5:0] v;
    v = r;
    if (r == 6'd0) begin
      v = 6'd1;
    end else if ({1'b0, r} > maxv) begin
      v = maxv[5:0];
    end
    return v;
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign rows_eff = eff_limit(rows_cfg, ROW_MAX);
  assign cols_eff = eff_limit(cols_cfg, COL_MAX);
  assign line_lim = vert ? rows_eff : cols_eff;
  assign pos      = vert ? pen_row : pen_col;

  // shared adder: end position during check, cell step during the walk
  always_comb begin
    if (state == S_LN_CHK) begin
      add_a = $signed({3'b000, pos});
      add_b = $signed({offset[7], offset});
    end else begin
      add_a = $signed({3'b000, cur});
      add_b = 9'sd1;
    end
    sum = add_a + add_b;
  end

  assign end6      = sum[5:0];
  assign pen_ok    = (pen_row != 6'd0) && (pen_row <= rows_eff) &&
                     (pen_col != 6'd0) && (pen_col <= cols_eff);
  assign end_ok    = (sum >= 9'sd1) && (sum <= $signed({3'b000, line_lim}));
  assign read_ok   = (read_row != 6'd0) && (read_row <= rows_eff) &&
                     (read_col != 6'd0) && (read_col <= cols_eff);
  assign printable = (char_code >= CH_SPACE) && (char_code <= CH_TILDE);

  assign ln_row = vert ? cur : pen_row;
  assign ln_col = vert ? pen_col : cur;
  assign ln_rm1 = ln_row - 6'd1;
  assign ln_cm1 = ln_col - 6'd1;
  assign rd_rm1 = read_row - 6'd1;
  assign rd_cm1 = read_col - 6'd1;

  always_comb begin
    mem_raddr = {ln_rm1[RW-1:0], ln_cm1[CW-1:0]};
    mem_waddr = {ln_rm1[RW-1:0], ln_cm1[CW-1:0]};
    mem_wdata = draw_char;
    mem_we    = 1'b0;
    if (state == S_IDLE) begin
      mem_raddr = {rd_rm1[RW-1:0], rd_cm1[CW-1:0]};
    end
    if (state == S_SWEEP) begin
      mem_waddr = sweep_cnt;
      mem_wdata = CH_SPACE;
      mem_we    = 1'b1;
    end else if (state == S_LN_WR) begin
      mem_we = !bg_mode || (mem_rdata == CH_SPACE);
    end
  end

  cglp_grid_mem #(
    .AW(AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_t'(cmd))
            CMD_CLEAR:            state_next = S_SWEEP;
            CMD_HLINE, CMD_VLINE: state_next = S_LN_CHK;
            CMD_READ:             state_next = read_ok ? S_RD_WAIT : S_IDLE;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_SWEEP:   if (&sweep_cnt) state_next = S_IDLE;
      S_LN_CHK:  state_next = (pen_ok && end_ok) ? S_LN_RD : S_IDLE;
      S_LN_RD:   state_next = S_LN_WR;
      S_LN_WR:   if (cur == hi) state_next = S_IDLE; else state_next = S_LN_RD;
      S_RD_WAIT: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg    <= GRID_RESET;
      cols_cfg    <= GRID_RESET;
      pen_row     <= 6'd1;
      pen_col     <= 6'd1;
      draw_char   <= CH_STAR;
      bg_mode     <= 1'b0;
      sweep_cnt   <= '0;
      sweep_reply <= 1'b0;
      done        <= 1'b0;
      status      <= ST_OK;
      cell_char   <= 8'd0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS: rows_cfg <= cfg_data;
          CFG_COLS: cols_cfg <= cfg_data;
          default:  ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            vert   <= (cmd_t'(cmd) == CMD_VLINE);
            offset <= distance;
            case (cmd_t'(cmd))
              CMD_BEGIN: begin
                pen_row   <= 6'd1;
                pen_col   <= 6'd1;
                done      <= 1'b1;
                status    <= ST_OK;
                cell_char <= 8'd0;
              end
              CMD_CLEAR: begin
                draw_char   <= CH_STAR;
                bg_mode     <= 1'b0;
                sweep_cnt   <= '0;
                sweep_reply <= 1'b1;
              end
              CMD_SET_FG, CMD_SET_BG: begin
                if (printable) begin
                  draw_char <= char_code;
                  bg_mode   <= (cmd_t'(cmd) == CMD_SET_BG);
                  status    <= ST_OK;
                end else begin
                  status <= ST_NONPRINT;
                end
                done      <= 1'b1;
                cell_char <= 8'd0;
              end
              CMD_HLINE, CMD_VLINE: ;
              CMD_READ: begin
                if (!read_ok) begin
                  done      <= 1'b1;
                  status    <= ST_OOB;
                  cell_char <= 8'd0;
                end
              end
              default: begin
                done      <= 1'b1;
                status    <= ST_OK;
                cell_char <= 8'd0;
              end
            endcase
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (&sweep_cnt) begin
            sweep_reply <= 1'b0;
            if (sweep_reply) begin
              done      <= 1'b1;
              status    <= ST_OK;
              cell_char <= 8'd0;
            end
          end
        end
        S_LN_CHK: begin
          if (pen_ok && end_ok) begin
            cur     <= (pos <= end6) ? pos : end6;
            hi      <= (pos <= end6) ? end6 : pos;
            end_pos <= end6;
          end else begin
            done      <= 1'b1;
            status    <= ST_OOB;
            cell_char <= 8'd0;
          end
        end
        S_LN_WR: begin
          if (cur == hi) begin
            if (vert) begin
              pen_row <= end_pos;
            end else begin
              pen_col <= end_pos;
            end
            done      <= 1'b1;
            status    <= ST_OK;
            cell_char <= 8'd0;
          end else begin
            cur <= sum[5:0];
          end
        end
        S_RD_WAIT: begin
          done      <= 1'b1;
          status    <= ST_OK;
          cell_char <= mem_rdata;
        end
        default: ;
      endcase
    end
  end

  `CGLP_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  `CGLP_ASSERT_NEXT(a_accept_resp, start && !busy, done || busy, "accepted command lost")
  `CGLP_ASSERT_SAME(a_cell_ok, done && (cell_char != 8'd0), status == ST_OK, "cell data on reject")

endmodule
